[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge out of reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// cond must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/nhr_pkg.sv]
// ----------------------------------------------------------------------------
// nhr_pkg
// Types and constants shared by the NAT header rewrite pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nhr_pkg;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // six 16-bit terms per side for L4, four for IP
    localparam int L4_PART_W = 19;
    localparam int IP_PART_W = 18;
    localparam int TOTAL_W   = 20;
    localparam int FOLD_W    = 17;

    typedef struct packed {
        logic [47:0] peer_dst_socket;
        logic [47:0] peer_src_socket;
        logic [15:0] l4_csum;
        logic [15:0] ip_csum;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [7:0]  ip_protocol;
        logic        dnat_on;
        logic        snat_on;
        logic        is_reply;
    } nhr_in_t;

    typedef struct packed {
        logic [15:0] l4_csum;
        logic [15:0] ip_csum;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } nhr_fields_t;

    typedef struct packed {
        nhr_fields_t            orig;
        nhr_fields_t            rewr;
        logic                   en_src;
        logic                   en_dst;
        logic [L4_PART_W-1:0]   l4_src_sum;
        logic [L4_PART_W-1:0]   l4_dst_sum;
        logic [IP_PART_W-1:0]   ip_src_sum;
        logic [IP_PART_W-1:0]   ip_dst_sum;
    } nhr_s1_t;

    typedef struct packed {
        nhr_fields_t            orig;
        nhr_fields_t            rewr;
        logic                   any;
        logic [FOLD_W-1:0]      l4_fold;
        logic [FOLD_W-1:0]      ip_fold;
    } nhr_s2_t;

    typedef struct packed {
        nhr_fields_t f;
        logic        was_rewritten;
    } nhr_out_t;

endpackage

`default_nettype wire

[rtl/nhr_select.sv]
// ----------------------------------------------------------------------------
// nhr_select
// Stage 1: rewrite selection, new socket fields and partial checksum sums.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nhr_select
    import nhr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire nhr_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output nhr_s1_t      out_data
);

    logic    valid_reg;
    nhr_s1_t data_reg;
    nhr_s1_t data_next;

    logic        is_l4;
    logic        do_src;
    logic        do_dst;
    logic [31:0] pd_addr;
    logic [15:0] pd_port;
    logic [31:0] ps_addr;
    logic [15:0] ps_port;
    logic [31:0] sa_inv;
    logic [31:0] da_inv;
    logic [15:0] sp_inv;
    logic [15:0] dp_inv;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        is_l4   = (in_data.ip_protocol == PROTO_TCP) || (in_data.ip_protocol == PROTO_UDP);
        do_src  = is_l4 && (in_data.is_reply ? in_data.dnat_on : in_data.snat_on);
        do_dst  = is_l4 && (in_data.is_reply ? in_data.snat_on : in_data.dnat_on);
        pd_addr = in_data.peer_dst_socket[47:16];
        pd_port = in_data.peer_dst_socket[15:0];
        ps_addr = in_data.peer_src_socket[47:16];
        ps_port = in_data.peer_src_socket[15:0];
        sa_inv  = ~in_data.src_addr;
        da_inv  = ~in_data.dst_addr;
        sp_inv  = ~in_data.src_port;
        dp_inv  = ~in_data.dst_port;

        data_next.orig.src_addr = in_data.src_addr;
        data_next.orig.dst_addr = in_data.dst_addr;
        data_next.orig.src_port = in_data.src_port;
        data_next.orig.dst_port = in_data.dst_port;
        data_next.orig.ip_csum  = in_data.ip_csum;
        data_next.orig.l4_csum  = in_data.l4_csum;

        data_next.rewr.src_addr = do_src ? pd_addr : in_data.src_addr;
        data_next.rewr.src_port = do_src ? pd_port : in_data.src_port;
        data_next.rewr.dst_addr = do_dst ? ps_addr : in_data.dst_addr;
        data_next.rewr.dst_port = do_dst ? ps_port : in_data.dst_port;
        data_next.rewr.ip_csum  = in_data.ip_csum;
        data_next.rewr.l4_csum  = in_data.l4_csum;

        data_next.en_src = do_src;
        data_next.en_dst = do_dst;

        data_next.ip_src_sum = {2'b00, sa_inv[31:16]} + {2'b00, sa_inv[15:0]}
                             + {2'b00, pd_addr[31:16]} + {2'b00, pd_addr[15:0]};
        data_next.ip_dst_sum = {2'b00, da_inv[31:16]} + {2'b00, da_inv[15:0]}
                             + {2'b00, ps_addr[31:16]} + {2'b00, ps_addr[15:0]};
        data_next.l4_src_sum = {1'b0, data_next.ip_src_sum} + {3'b000, sp_inv}
                             + {3'b000, pd_port};
        data_next.l4_dst_sum = {1'b0, data_next.ip_dst_sum} + {3'b000, dp_inv}
                             + {3'b000, ps_port};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    `ASSERT_CLK(a_s1_hold, clk, rst_n,
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg),
        "stage 1 item lost or changed under stall")

    `ASSERT_NEVER(a_s1_proto, clk, rst_n,
        valid_reg && (data_reg.rewr.src_addr != data_reg.orig.src_addr) && !data_reg.en_src,
        "source address changed without source rewrite")

endmodule

`default_nettype wire

[rtl/nhr_sum.sv]
// ----------------------------------------------------------------------------
// nhr_sum
// Stage 2: full one's-complement sums and first end-around-carry fold.
// ----------------------------------------------------------------------------
`default_nettype none

module nhr_sum
    import nhr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire nhr_s1_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output nhr_s2_t      out_data
);

    logic    valid_reg;
    nhr_s2_t data_reg;
    nhr_s2_t data_next;

    logic [15:0]        l4_inv;
    logic [15:0]        ip_inv;
    logic [TOTAL_W-1:0] l4_total;
    logic [TOTAL_W-1:0] ip_total;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        l4_inv = ~in_data.orig.l4_csum;
        ip_inv = ~in_data.orig.ip_csum;

        l4_total = {4'b0000, l4_inv}
                 + (in_data.en_src ? {1'b0, in_data.l4_src_sum} : {TOTAL_W{1'b0}})
                 + (in_data.en_dst ? {1'b0, in_data.l4_dst_sum} : {TOTAL_W{1'b0}});
        ip_total = {4'b0000, ip_inv}
                 + (in_data.en_src ? {2'b00, in_data.ip_src_sum} : {TOTAL_W{1'b0}})
                 + (in_data.en_dst ? {2'b00, in_data.ip_dst_sum} : {TOTAL_W{1'b0}});

        data_next.orig    = in_data.orig;
        data_next.rewr    = in_data.rewr;
        data_next.any     = in_data.en_src || in_data.en_dst;
        data_next.l4_fold = {1'b0, l4_total[15:0]} + {13'd0, l4_total[TOTAL_W-1:16]};
        data_next.ip_fold = {1'b0, ip_total[15:0]} + {13'd0, ip_total[TOTAL_W-1:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/nhr_finish.sv]
// ----------------------------------------------------------------------------
// nhr_finish
// Stage 3: final fold, checksum complement, change flag; output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nhr_finish
    import nhr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire nhr_s2_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output nhr_out_t     out_data
);

    logic     valid_reg;
    logic     any_reg;
    nhr_out_t data_reg;
    nhr_out_t data_next;

    logic [15:0] l4_sum;
    logic [15:0] ip_sum;
    logic [15:0] l4_new;
    logic [15:0] ip_new;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // second fold cannot carry again
        l4_sum = in_data.l4_fold[15:0] + {15'd0, in_data.l4_fold[16]};
        ip_sum = in_data.ip_fold[15:0] + {15'd0, in_data.ip_fold[16]};
        // a zero sum stands for 0xFFFF
        l4_new = (l4_sum == 16'h0000) ? 16'h0000 : ~l4_sum;
        ip_new = (ip_sum == 16'h0000) ? 16'h0000 : ~ip_sum;

        data_next.f         = in_data.rewr;
        data_next.f.l4_csum = in_data.any ? l4_new : in_data.orig.l4_csum;
        data_next.f.ip_csum = in_data.any ? ip_new : in_data.orig.ip_csum;
        data_next.was_rewritten = (data_next.f != in_data.orig);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            any_reg  <= in_data.any;
        end
    end

    `ASSERT_NEVER(a_l4_csum_ffff, clk, rst_n,
        valid_reg && any_reg && (data_reg.f.l4_csum == 16'hFFFF),
        "updated L4 checksum is 0xFFFF")

    `ASSERT_NEVER(a_ip_csum_ffff, clk, rst_n,
        valid_reg && any_reg && (data_reg.f.ip_csum == 16'hFFFF),
        "updated IP checksum is 0xFFFF")

    `ASSERT_NEVER(a_pass_flag, clk, rst_n,
        valid_reg && !any_reg && data_reg.was_rewritten,
        "item without rewrite flagged as changed")

endmodule

`default_nettype wire

[rtl/nat_header_rewrite_incremental_csum_core.sv]
// ----------------------------------------------------------------------------
// nat_header_rewrite_incremental_csum_core
// IPv4 TCP/UDP NAT address/port rewrite with incremental checksum update.
// ----------------------------------------------------------------------------
//  channel  dir  tdata  tuser  accepted on
//  s_axis   in   224    11     s_tvalid && s_tready
//  m_axis   out  128    1      m_tvalid && m_tready
//
//  Three register stages: select/partial sums, sum/fold, final fold/output.
//  One item per cycle sustained while m_tready stays high, set by the ready chain.
//  Ready ripples back through the stages; a bubble in any stage is filled.
//  Reset clears only the stage valid bits; no clearing pass.
//  A stalled item holds in its stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_header_rewrite_incremental_csum_core
    import nhr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // src_addr, dst_addr, src_port, dst_port, ip_csum, l4_csum,
    // peer_src_socket, peer_dst_socket
    input  wire logic [223:0] s_tdata,
    // is_reply, snat_on, dnat_on, ip_protocol
    input  wire logic [10:0]  s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_src_addr, out_dst_addr, out_src_port, out_dst_port, out_ip_csum,
    // out_l4_csum
    output logic [127:0]      m_tdata,
    // was_rewritten
    output logic [0:0]        m_tuser
);

    nhr_in_t  in_item;
    nhr_s1_t  s1_data;
    nhr_s2_t  s2_data;
    nhr_out_t out_item;
    logic     s1_valid;
    logic     s1_ready;
    logic     s2_valid;
    logic     s2_ready;

    always_comb
    begin
        in_item.is_reply        = s_tuser[0];
        in_item.snat_on         = s_tuser[1];
        in_item.dnat_on         = s_tuser[2];
        in_item.ip_protocol     = s_tuser[10:3];
        in_item.src_addr        = s_tdata[31:0];
        in_item.dst_addr        = s_tdata[63:32];
        in_item.src_port        = s_tdata[79:64];
        in_item.dst_port        = s_tdata[95:80];
        in_item.ip_csum         = s_tdata[111:96];
        in_item.l4_csum         = s_tdata[127:112];
        in_item.peer_src_socket = s_tdata[175:128];
        in_item.peer_dst_socket = s_tdata[223:176];
    end

    nhr_select u_select
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    nhr_sum u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    nhr_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = {out_item.f.l4_csum, out_item.f.ip_csum,
                      out_item.f.dst_port, out_item.f.src_port,
                      out_item.f.dst_addr, out_item.f.src_addr};
    assign m_tuser = out_item.was_rewritten;

endmodule

`default_nettype wire
